// ===== rtl/core/pcxrle_pkg.sv =====
// Shared constants and types for the PCX run-length decoder with clipped blit.
package pcxrle_pkg;

   localparam int MAX_DIM = 4096;
   localparam int COL_W   = $clog2(MAX_DIM);
   localparam int DIM_W   = COL_W + 1;
   localparam int ROW_W   = DIM_W;
   localparam int BROW_W  = ROW_W + 1;
   localparam int ADDR_W  = 24;
   localparam int PIX_W   = 8;
   localparam int RUN_W   = 6;
   localparam int CSR_W   = DIM_W;
   localparam int CSR_IDX_W = 3;

   localparam logic [PIX_W-1:0] COUNT_MARK = 8'hBF;
   localparam logic [PIX_W-1:0] COUNT_MASK = 8'h3F;
   localparam logic [DIM_W-1:0] MAX_DIM_V  = DIM_W'(MAX_DIM);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH   = 3'd0,
      CSR_IMAGE_HEIGHT  = 3'd1,
      CSR_BUFFER_WIDTH  = 3'd2,
      CSR_BUFFER_HEIGHT = 3'd3,
      CSR_ORIGIN_X      = 3'd4,
      CSR_ORIGIN_Y      = 3'd5,
      CSR_TRANSPARENT   = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [DIM_W-1:0] image_width;
      logic [DIM_W-1:0] image_height;
      logic [DIM_W-1:0] buffer_width;
      logic [DIM_W-1:0] buffer_height;
      logic [COL_W-1:0] origin_x;
      logic [COL_W-1:0] origin_y;
      logic             transparent_enable;
   } blit_cfg_type;

   typedef struct packed {
      logic              wrote;
      logic [ADDR_W-1:0] address;
      logic [COL_W-1:0]  next_column;
      logic [ROW_W-1:0]  next_row;
   } pixel_result_type;

   typedef struct packed {
      logic              valid;
      logic [ADDR_W-1:0] address;
      logic [PIX_W-1:0]  pixel;
      logic              last;
   } write_beat_type;

endpackage

// ===== rtl/core/pcxrle_pixel_unit.sv =====
// Shared pixel unit: clip test, linear address and raster position advance.
module pcxrle_pixel_unit
   import pcxrle_pkg::*;
(
   input  blit_cfg_type     cfg,
   input  logic [COL_W-1:0] column,
   input  logic [ROW_W-1:0] row,
   input  logic [PIX_W-1:0] pixel,
   output pixel_result_type result
);

   logic [DIM_W-1:0]  eff_width;
   logic [DIM_W-1:0]  buf_col;
   logic [BROW_W-1:0] buf_row;
   logic [DIM_W-1:0]  col_inc;
   logic [BROW_W+DIM_W-1:0] product;
   logic [BROW_W+DIM_W-1:0] sum;
   logic in_image;
   logic skip;

   always_comb begin
      if (cfg.image_width == '0) begin
         eff_width = DIM_W'(1);
      end else if (cfg.image_width > MAX_DIM_V) begin
         eff_width = MAX_DIM_V;
      end else begin
         eff_width = cfg.image_width;
      end

      in_image = row < cfg.image_height;
      buf_col  = {1'b0, cfg.origin_x} + {1'b0, column};
      buf_row  = {2'b00, cfg.origin_y} + {1'b0, row};
      skip     = cfg.transparent_enable && (pixel == '0);
      product  = buf_row * cfg.buffer_width;
      sum      = product + (BROW_W+DIM_W)'(buf_col);

      result.wrote   = in_image && (buf_col < cfg.buffer_width)
                       && (buf_row < {1'b0, cfg.buffer_height}) && !skip;
      result.address = sum[ADDR_W-1:0];

      col_inc = {1'b0, column} + DIM_W'(1);
      if (!in_image) begin
         result.next_column = column;
         result.next_row    = row;
      end else if (col_inc >= eff_width) begin
         result.next_column = '0;
         result.next_row    = row + ROW_W'(1);
      end else begin
         result.next_column = col_inc[COL_W-1:0];
         result.next_row    = row;
      end
   end

endmodule

// ===== rtl/core/pcxrle_out_reg.sv =====
// Output register that holds one write beat toward the result channel.
module pcxrle_out_reg
   import pcxrle_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  write_beat_type    push,
   output logic              free,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [ADDR_W-1:0] rsp_write_address,
   output logic [PIX_W-1:0]  rsp_pixel_value,
   output logic              rsp_last_of_run
);

   logic              valid_ff;
   logic [ADDR_W-1:0] address_ff;
   logic [PIX_W-1:0]  pixel_ff;
   logic              last_ff;

   assign free = !valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (free) begin
         valid_ff <= push.valid;
      end
      if (free && push.valid) begin
         address_ff <= push.address;
         pixel_ff   <= push.pixel;
         last_ff    <= push.last;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_write_address = address_ff;
   assign rsp_pixel_value   = pixel_ff;
   assign rsp_last_of_run   = last_ff;

endmodule

// ===== rtl/core/pcx_rle_decode_blit_core.sv =====
// Top level of the PCX run-length decoder with clipped blit into a buffer.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  stream_byte, image_start
//   rsp      out        rsp_valid/rsp_stall  write_address, pixel_value, last_of_run
//   csr      in         csr_wr_en            csr_index, csr_wdata
//
// A count byte is only accepted. A literal byte is accepted, then takes one pixel step
// and a closing step. A value byte after a count of n is accepted, then takes a pixel
// step for each of the n pixels and a closing step; with n zero it is only accepted.
// The shared pixel unit places one pixel per cycle while no pixel step waits. Reset is
// synchronous; it restores the register defaults and clears the decoder. A pixel step
// or the closing step waits while a pending write meets a full, stalled output register.
module pcx_rle_decode_blit_core
   import pcxrle_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [PIX_W-1:0]     req_stream_byte,
   input  logic                 req_image_start,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [ADDR_W-1:0]    rsp_write_address,
   output logic [PIX_W-1:0]     rsp_pixel_value,
   output logic                 rsp_last_of_run,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FLUSH
   } state_type;

   blit_cfg_type     cfg_ff;
   state_type        state_ff, state_in;
   logic             awaiting_ff, awaiting_in;
   logic [RUN_W-1:0] run_length_ff, run_length_in;
   logic [RUN_W-1:0] remain_ff, remain_in;
   logic [PIX_W-1:0] value_ff, value_in;
   logic [COL_W-1:0] column_ff, column_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic              pend_v_ff, pend_v_in;
   logic [ADDR_W-1:0] pend_addr_ff, pend_addr_in;
   logic [PIX_W-1:0]  pend_pix_ff, pend_pix_in;

   pixel_result_type pix;
   write_beat_type   push;
   logic             out_free;
   logic             accept;
   logic             step;
   logic             aw0;
   logic [RUN_W-1:0] rl0;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width        <= DIM_W'(1);
         cfg_ff.image_height       <= DIM_W'(1);
         cfg_ff.buffer_width       <= DIM_W'(1);
         cfg_ff.buffer_height      <= DIM_W'(1);
         cfg_ff.origin_x           <= '0;
         cfg_ff.origin_y           <= '0;
         cfg_ff.transparent_enable <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:   cfg_ff.image_width        <= csr_wdata;
            CSR_IMAGE_HEIGHT:  cfg_ff.image_height       <= csr_wdata;
            CSR_BUFFER_WIDTH:  cfg_ff.buffer_width       <= csr_wdata;
            CSR_BUFFER_HEIGHT: cfg_ff.buffer_height      <= csr_wdata;
            CSR_ORIGIN_X:      cfg_ff.origin_x           <= csr_wdata[COL_W-1:0];
            CSR_ORIGIN_Y:      cfg_ff.origin_y           <= csr_wdata[COL_W-1:0];
            CSR_TRANSPARENT:   cfg_ff.transparent_enable <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   pcxrle_pixel_unit u_pixel (
      .cfg    (cfg_ff),
      .column (column_ff),
      .row    (row_ff),
      .pixel  (value_ff),
      .result (pix)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign step      = !(pix.wrote && pend_v_ff) || out_free;

   always_comb begin
      state_in      = state_ff;
      awaiting_in   = awaiting_ff;
      run_length_in = run_length_ff;
      remain_in     = remain_ff;
      value_in      = value_ff;
      column_in     = column_ff;
      row_in        = row_ff;
      pend_v_in     = pend_v_ff;
      pend_addr_in  = pend_addr_ff;
      pend_pix_in   = pend_pix_ff;
      push.valid    = 1'b0;
      push.address  = pend_addr_ff;
      push.pixel    = pend_pix_ff;
      push.last     = (state_ff == ST_FLUSH);
      aw0           = req_image_start ? 1'b0 : awaiting_ff;
      rl0           = req_image_start ? '0 : run_length_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_image_start) begin
                  column_in = '0;
                  row_in    = '0;
               end
               if (aw0) begin
                  awaiting_in   = 1'b0;
                  run_length_in = '0;
                  value_in      = req_stream_byte;
                  remain_in     = rl0;
                  state_in      = (rl0 != '0) ? ST_RUN : ST_IDLE;
               end else if (req_stream_byte > COUNT_MARK) begin
                  awaiting_in   = 1'b1;
                  run_length_in = RUN_W'(req_stream_byte & COUNT_MASK);
               end else begin
                  awaiting_in   = 1'b0;
                  run_length_in = '0;
                  value_in      = req_stream_byte;
                  remain_in     = RUN_W'(1);
                  state_in      = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            if (step) begin
               column_in = pix.next_column;
               row_in    = pix.next_row;
               remain_in = remain_ff - RUN_W'(1);
               if (pix.wrote) begin
                  push.valid   = pend_v_ff;
                  pend_v_in    = 1'b1;
                  pend_addr_in = pix.address;
                  pend_pix_in  = value_ff;
               end
               if (remain_ff == RUN_W'(1)) begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (!pend_v_ff || out_free) begin
               push.valid = pend_v_ff;
               pend_v_in  = 1'b0;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         awaiting_ff   <= 1'b0;
         run_length_ff <= '0;
         remain_ff     <= '0;
         column_ff     <= '0;
         row_ff        <= '0;
         pend_v_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         awaiting_ff   <= awaiting_in;
         run_length_ff <= run_length_in;
         remain_ff     <= remain_in;
         column_ff     <= column_in;
         row_ff        <= row_in;
         pend_v_ff     <= pend_v_in;
      end
      value_ff     <= value_in;
      pend_addr_ff <= pend_addr_in;
      pend_pix_ff  <= pend_pix_in;
   end

   pcxrle_out_reg u_out (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .free              (out_free),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_write_address (rsp_write_address),
      .rsp_pixel_value   (rsp_pixel_value),
      .rsp_last_of_run   (rsp_last_of_run)
   );

   // A beat is handed to the output register only when it can take it.
   a_push_free: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> out_free)
      else $error("write beat pushed into a full output register");

   // No write may be left waiting when a new byte is taken.
   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_v_ff)
      else $error("pending write left behind in idle");

   // A run in progress always has pixels left to place.
   a_run_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (remain_ff != '0))
      else $error("pixel run entered with no pixels left");

   // The stored count is meaningful only while its value byte is awaited.
   a_count_cleared: assert property (@(posedge clock) disable iff (reset)
      !awaiting_ff |-> (run_length_ff == '0))
      else $error("run length kept without an awaited value byte");

endmodule

// ===== tb/sv/tb_pcx_rle_decode_blit_core.sv =====
// Self-checking testbench for the PCX run-length decoder with clipped blit.
module tb_pcx_rle_decode_blit_core;
   timeunit 1ns;
   timeprecision 1ps;

   import pcxrle_pkg::*;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int SETTLE_TICKS = 80;
   localparam int LONG_HOLD    = 400;

   typedef struct {
      logic [PIX_W-1:0] sbyte;
      logic             start;
   } stream_beat_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [PIX_W-1:0]     req_stream_byte = '0;
   logic                 req_image_start = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [ADDR_W-1:0]    rsp_write_address;
   logic [PIX_W-1:0]     rsp_pixel_value;
   logic                 rsp_last_of_run;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;

   stream_beat_type pending_bytes[$];
   write_beat_type  expected_writes[$];

   // Mirror of the block's registers and decoder position.
   logic [12:0] cfg_image_w = 13'd1;
   logic [12:0] cfg_image_h = 13'd1;
   logic [12:0] cfg_buf_w = 13'd1;
   logic [12:0] cfg_buf_h = 13'd1;
   logic [11:0] cfg_org_x = '0;
   logic [11:0] cfg_org_y = '0;
   logic        cfg_transparent = 1'b0;
   logic        awaiting_value = 1'b0;
   logic [5:0]  run_count = '0;
   logic [11:0] img_col = '0;
   logic [12:0] img_row = '0;

   int  error_count = 0;
   int  cycle_count = 0;
   int  req_gap = 0;
   int  stall_left = 0;
   int  hold_left = 0;
   int  hold_ticket = 0;
   int  hold_served = 0;
   bit  quiet = 1'b0;
   bit  req_taken = 1'b0;

   pcx_rle_decode_blit_core u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_stream_byte   (req_stream_byte),
      .req_image_start   (req_image_start),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_write_address (rsp_write_address),
      .rsp_pixel_value   (rsp_pixel_value),
      .rsp_last_of_run   (rsp_last_of_run),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void decode_byte(input logic [PIX_W-1:0] sbyte, input logic start);
      write_beat_type batch[$];
      write_beat_type beat;
      logic [PIX_W-1:0] value;
      int unsigned count;
      int unsigned eff_w;
      longint unsigned bcol;
      longint unsigned brow;
      if (start) begin
         awaiting_value = 1'b0;
         run_count = '0;
         img_col = '0;
         img_row = '0;
      end
      if (awaiting_value) begin
         value = sbyte;
         count = run_count;
         awaiting_value = 1'b0;
         run_count = '0;
      end else if (sbyte > COUNT_MARK) begin
         run_count = 6'(sbyte & COUNT_MASK);
         awaiting_value = 1'b1;
         return;
      end else begin
         value = sbyte;
         count = 1;
      end
      eff_w = (cfg_image_w == 0) ? 1 : (cfg_image_w > MAX_DIM) ? MAX_DIM : cfg_image_w;
      for (int i = 0; i < count; i++) begin
         if (img_row < cfg_image_h) begin
            bcol = longint'(cfg_org_x) + img_col;
            brow = longint'(cfg_org_y) + img_row;
            if (bcol < cfg_buf_w && brow < cfg_buf_h && !(cfg_transparent && value == 0)) begin
               beat.valid = 1'b1;
               beat.address = ADDR_W'(brow * cfg_buf_w + bcol);
               beat.pixel = value;
               beat.last = 1'b0;
               batch.push_back(beat);
            end
            if (int'(img_col) + 1 >= eff_w) begin
               img_col = '0;
               img_row = img_row + 1'b1;
            end else begin
               img_col = img_col + 1'b1;
            end
         end
      end
      if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
      foreach (batch[i]) expected_writes.push_back(batch[i]);
   endfunction

   task automatic report_mismatch(input string field, input int unsigned want,
                                  input int unsigned got);
      error_count++;
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
   endtask

   always @(posedge clock) begin : req_sampler
      req_taken = !reset && req_valid && !req_stall;
      if (req_taken) decode_byte(req_stream_byte, req_image_start);
   end

   always @(posedge clock) begin : rsp_monitor
      write_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_writes.size() == 0) begin
            error_count++;
            $error("write with none expected: address 0x%0h pixel 0x%0h",
                   rsp_write_address, rsp_pixel_value);
         end else begin
            want = expected_writes.pop_front();
            if (rsp_write_address !== want.address)
               report_mismatch("write_address", want.address, rsp_write_address);
            if (rsp_pixel_value !== want.pixel)
               report_mismatch("pixel_value", want.pixel, rsp_pixel_value);
            if (rsp_last_of_run !== want.last)
               report_mismatch("last_of_run", want.last, rsp_last_of_run);
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(negedge clock) begin : req_driver
      stream_beat_type nxt;
      logic offer;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_taken && !quiet && $urandom_range(0, 4) == 0) req_gap = $urandom_range(1, 10);
         offer = req_valid && !req_taken;
         if (!offer) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (pending_bytes.size() > 0) begin
               nxt = pending_bytes.pop_front();
               req_stream_byte <= nxt.sbyte;
               req_image_start <= nxt.start;
               offer = 1'b1;
            end
         end
         req_valid <= offer;
      end
   end

   always @(negedge clock) begin : rsp_staller
      logic hold;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_ticket != hold_served) begin
            hold_served = hold_ticket;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            hold = 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            hold = 1'b1;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 10) - 1;
            hold = 1'b1;
         end else begin
            hold = 1'b0;
         end
         rsp_stall <= hold;
      end
   end

   task automatic write_csr(input csr_index_type idx, input int unsigned value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_W'(value);
      case (idx)
         CSR_IMAGE_WIDTH:   cfg_image_w = 13'(value);
         CSR_IMAGE_HEIGHT:  cfg_image_h = 13'(value);
         CSR_BUFFER_WIDTH:  cfg_buf_w = 13'(value);
         CSR_BUFFER_HEIGHT: cfg_buf_h = 13'(value);
         CSR_ORIGIN_X:      cfg_org_x = 12'(value);
         CSR_ORIGIN_Y:      cfg_org_y = 12'(value);
         CSR_TRANSPARENT:   cfg_transparent = 1'(value);
         default: ;
      endcase
   endtask

   task automatic configure(input int unsigned iw, input int unsigned ih, input int unsigned bw,
                            input int unsigned bh, input int unsigned ox, input int unsigned oy,
                            input int unsigned tr);
      write_csr(CSR_IMAGE_WIDTH, iw);
      write_csr(CSR_IMAGE_HEIGHT, ih);
      write_csr(CSR_BUFFER_WIDTH, bw);
      write_csr(CSR_BUFFER_HEIGHT, bh);
      write_csr(CSR_ORIGIN_X, ox);
      write_csr(CSR_ORIGIN_Y, oy);
      write_csr(CSR_TRANSPARENT, tr);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic push_byte(input logic [PIX_W-1:0] sbyte, input logic start);
      stream_beat_type beat;
      beat.sbyte = sbyte;
      beat.start = start;
      pending_bytes.push_back(beat);
   endtask

   task automatic push_random_stream(input int n);
      int k;
      int pick;
      logic [5:0] cnt;
      k = 0;
      while (k < n) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            push_byte(($urandom_range(0, 4) == 0) ? 8'h00 : 8'($urandom_range(0, 191)),
                      k == 0 || $urandom_range(0, 24) == 0);
            k++;
         end else if (pick < 90) begin
            cnt = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                              : 6'($urandom_range(0, 7));
            push_byte(8'hC0 | cnt, k == 0 || $urandom_range(0, 24) == 0);
            push_byte(8'($urandom_range(0, 255)), 1'b0);
            k += 2;
         end else begin
            push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            k++;
         end
      end
   endtask

   task automatic wait_idle();
      while (pending_bytes.size() != 0 || req_valid || expected_writes.size() != 0)
         @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Register defaults: a one-pixel image, so only the first pixel lands.
      push_byte(8'h5A, 1'b1);
      push_byte(8'h33, 1'b0);
      wait_idle();

      // Clipping on the right and bottom edges, zero count, long run past the image end,
      // and a start flag that cuts off a pending count.
      configure(8, 4, 16, 8, 12, 5, 0);
      push_byte(8'h00, 1'b1);
      push_byte(8'hBF, 1'b0);
      push_byte(8'hC0, 1'b0);
      push_byte(8'h11, 1'b0);
      push_byte(8'hC3, 1'b0);
      push_byte(8'hFE, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h7F, 1'b0);
      push_byte(8'h01, 1'b0);
      push_byte(8'hC4, 1'b0);
      push_byte(8'h40, 1'b1);
      push_byte(8'hC2, 1'b1);
      push_byte(8'h80, 1'b0);
      wait_idle();

      // Transparent mode skips zero pixels, including whole runs of them.
      configure(4, 3, 4, 3, 0, 0, 1);
      push_byte(8'hC6, 1'b1);
      push_byte(8'h00, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'hC2, 1'b0);
      push_byte(8'h05, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'h09, 1'b0);
      wait_idle();

      // A zero image width behaves as width one.
      configure(0, 5, 3, 8, 1, 2, 0);
      push_byte(8'hC4, 1'b1);
      push_byte(8'h77, 1'b0);
      wait_idle();

      // A zero image height drops every pixel.
      configure(5, 0, 5, 5, 0, 0, 0);
      push_byte(8'h21, 1'b1);
      push_byte(8'hC5, 1'b0);
      push_byte(8'h22, 1'b0);
      wait_idle();

      // Oversized width at the far corner of the largest buffer.
      configure(8191, 2, 4096, 4096, 4095, 4095, 0);
      push_byte(8'h12, 1'b1);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h34, 1'b0);
      wait_idle();

      // Addresses that overflow 24 bits.
      configure(3, 3, 8191, 8191, 4095, 4095, 1);
      push_byte(8'hC8, 1'b1);
      push_byte(8'h3C, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'h55, 1'b0);
      wait_idle();

      // Last row of a full-size buffer.
      configure(4096, 4096, 4096, 4096, 0, 4095, 0);
      push_byte(8'hFF, 1'b1);
      push_byte(8'hA5, 1'b0);
      wait_idle();

      for (int phase = 0; phase < 4; phase++) begin
         if (phase == 3) quiet = 1'b1;
         configure($urandom_range(1, 12), $urandom_range(1, 8), $urandom_range(1, 16),
                   $urandom_range(1, 12), $urandom_range(0, 6), $urandom_range(0, 4),
                   $urandom_range(0, 1));
         if (phase == 1) hold_ticket++;
         push_random_stream(16);
         wait_idle();
      end

      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== pcx_rle_decode_blit_core.f =====
rtl/core/pcxrle_pkg.sv
rtl/core/pcxrle_pixel_unit.sv
rtl/core/pcxrle_out_reg.sv
rtl/core/pcx_rle_decode_blit_core.sv
tb/sv/tb_pcx_rle_decode_blit_core.sv
